FILE: src/ftrc_pkg.sv
// Shared widths, constants, configuration codes, sideband types and the arctangent table.
package ftrc_pkg;

    localparam int DIR_W  = 25;
    localparam int XW     = 52;
    localparam int ZW     = 20;
    localparam int EW     = 18;
    localparam int ANG_W  = 15;
    localparam int SIZE_W = 14;
    localparam int RATE_W = 20;
    localparam int MAX_W  = 19;
    localparam int TTT_W  = 16;
    localparam int PROD_W = 33;
    localparam int DES_W  = 22;
    localparam int DMAG_W = 21;
    localparam int CFG_W  = 16;

    localparam logic signed [ZW-1:0] HALF_PI_Z = 20'sd102944;
    localparam logic signed [EW-1:0] PI_E      = 18'sd12868;
    localparam logic signed [EW-1:0] HALF_PI_E = 18'sd6434;
    localparam logic signed [EW-1:0] TWO_PI_E  = 18'sd25736;

    typedef enum logic [1:0] {
        CFG_FLEE           = 2'd0,
        CFG_TARGET_RADIUS  = 2'd1,
        CFG_SLOW_RADIUS    = 2'd2,
        CFG_TIME_TO_TARGET = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic [MAX_W-1:0]         maxa;
    } t_carry;

    typedef struct packed {
        t_carry c;
        logic   neg;
        logic   arrived;
        logic   full;
        logic   zero;
    } t_side1;

    typedef struct packed {
        t_carry c;
        logic   arrived;
        logic   dneg;
        logic   dzero;
        logic   sat;
    } t_side2;

    // Arctangent of 2^-i in Q.16 radians.
    function automatic logic signed [ZW-1:0] ftrc_atan(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 20'sd51472;
            1: v = 20'sd30386;
            2: v = 20'sd16055;
            3: v = 20'sd8150;
            4: v = 20'sd4091;
            5: v = 20'sd2047;
            6: v = 20'sd1024;
            7: v = 20'sd512;
            default: v = (i > 30) ? '0 : ZW'(65536 >> i);
        endcase
        return v;
    endfunction

endpackage

FILE: src/ftrc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module ftrc_div #(
    parameter int DW = 14,
    parameter int QW = 19,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_v    [1:QW];
    logic [DW-1:0] r_rem  [1:QW];
    logic [QW-1:0] r_low  [1:QW];
    logic [SW-1:0] r_side [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          w_v_in;
        logic [DW-1:0] w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [SW-1:0] w_side_in;
        logic [DW:0]   w_trial;
        logic          w_ge;
        logic [DW:0]   w_diff;

        if (k == 0) begin : g_in
            assign w_v_in    = i_valid;
            assign w_rem_in  = i_rem;
            assign w_low_in  = i_low;
            assign w_side_in = i_side;
        end else begin : g_in
            assign w_v_in    = r_v[k];
            assign w_rem_in  = r_rem[k];
            assign w_low_in  = r_low[k];
            assign w_side_in = r_side[k];
        end

        always_comb begin
            w_trial = {w_rem_in, w_low_in[QW-1]};
            w_ge    = w_trial >= {1'b0, i_div};
            w_diff  = w_trial - {1'b0, i_div};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= w_v_in;
            end
            r_rem[k+1]  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_low[k+1]  <= {w_low_in[QW-2:0], w_ge};
            r_side[k+1] <= w_side_in;
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_low[QW];
    assign o_side  = r_side[QW];

endmodule

FILE: src/face_target_rotation_controller_top.sv
// Top level of the face-target rotation controller: direction, CORDIC angle, error and rate control.
//
// The block turns an agent toward a target point, or away from it in flee mode, by
// commanding an angular acceleration. It is a fully pipelined datapath: a beat is accepted
// on every clock edge at which start is high, busy is always low, and every beat yields
// exactly one result beat, marked by o_done for a single cycle. The pipeline holds one
// register stage per CORDIC step and two restoring dividers of nineteen stages each,
// one for the slow-radius scaling and one for the time-to-target division. Results leave in
// the order the beats came in and the receiver cannot hold them off. Configuration writes
// take effect at once and should be made only while no beat is in flight.
module face_target_rotation_controller_top
    import ftrc_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [23:0]       i_agent_x,
    input  logic signed [23:0]       i_agent_y,
    input  logic signed [23:0]       i_target_x,
    input  logic signed [23:0]       i_target_y,
    input  logic signed [ANG_W-1:0]  i_facing,
    input  logic signed [RATE_W-1:0] i_rotation_rate,
    input  logic [MAX_W-1:0]         i_max_angular_accel,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_done,
    output logic signed [RATE_W-1:0] o_angular_accel,
    output logic signed [RATE_W-1:0] o_rotation_rate_out,
    output logic                     o_arrived
);

    localparam int N = CORDIC_STEPS;

    // Configuration registers.
    logic              r_flee;
    logic [SIZE_W-1:0] r_target_radius;
    logic [SIZE_W-1:0] r_slow_radius;
    logic [TTT_W-1:0]  r_ttt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flee          <= 1'b0;
            r_target_radius <= 14'd41;
            r_slow_radius   <= 14'd2048;
            r_ttt           <= 16'd410;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FLEE:           r_flee          <= i_cfg_data[0];
                CFG_TARGET_RADIUS:  r_target_radius <= i_cfg_data[SIZE_W-1:0];
                CFG_SLOW_RADIUS:    r_slow_radius   <= i_cfg_data[SIZE_W-1:0];
                CFG_TIME_TO_TARGET: r_ttt           <= i_cfg_data;
                default:            r_flee          <= r_flee;
            endcase
        end
    end

    // The pipeline never stalls, so a beat is taken on every start.
    assign busy = 1'b0;

    // Stage A: direction vector, reversed in flee mode by swapping the operands.
    logic                    r_a_v;
    logic signed [DIR_W-1:0] r_a_dx, r_a_dy;
    logic signed [ANG_W-1:0] r_a_facing;
    t_carry                  r_a_c;
    logic signed [DIR_W-1:0] w_ax, w_ay, w_tx, w_ty;

    always_comb begin
        w_ax = {i_agent_x[23], i_agent_x};
        w_ay = {i_agent_y[23], i_agent_y};
        w_tx = {i_target_x[23], i_target_x};
        w_ty = {i_target_y[23], i_target_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start;
        end
        r_a_dx      <= r_flee ? (w_ax - w_tx) : (w_tx - w_ax);
        r_a_dy      <= r_flee ? (w_ay - w_ty) : (w_ty - w_ay);
        r_a_facing  <= i_facing;
        r_a_c.rate  <= i_rotation_rate;
        r_a_c.maxa  <= i_max_angular_accel;
    end

    // Stage B: scale by 2^24 and rotate a left-half vector into the right half.
    logic                    r_cv [0:N];
    logic signed [XW-1:0]    r_cx [0:N];
    logic signed [XW-1:0]    r_cy [0:N];
    logic signed [ZW-1:0]    r_cz [0:N];
    logic signed [ANG_W-1:0] r_cf [0:N];
    t_carry                  r_cc [0:N];
    logic signed [XW-1:0]    w_bx, w_by;

    always_comb begin
        w_bx = {{3{r_a_dx[DIR_W-1]}}, r_a_dx, 24'd0};
        w_by = {{3{r_a_dy[DIR_W-1]}}, r_a_dy, 24'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else begin
            r_cv[0] <= r_a_v;
        end
        if (r_a_dx < 0) begin
            if (r_a_dy >= 0) begin
                r_cx[0] <= w_by;
                r_cy[0] <= -w_bx;
                r_cz[0] <= HALF_PI_Z;
            end else begin
                r_cx[0] <= -w_by;
                r_cy[0] <= w_bx;
                r_cz[0] <= -HALF_PI_Z;
            end
        end else begin
            r_cx[0] <= w_bx;
            r_cy[0] <= w_by;
            r_cz[0] <= '0;
        end
        r_cf[0] <= r_a_facing;
        r_cc[0] <= r_a_c;
    end

    // CORDIC vectoring, one micro-rotation per stage; a vector on the axis is left alone.
    for (genvar i = 0; i < N; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else begin
                r_cv[i+1] <= r_cv[i];
            end
            if (r_cy[i] > 0) begin
                r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                r_cz[i+1] <= r_cz[i] + ftrc_atan(i);
            end else if (r_cy[i] < 0) begin
                r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                r_cz[i+1] <= r_cz[i] - ftrc_atan(i);
            end else begin
                r_cx[i+1] <= r_cx[i];
                r_cy[i+1] <= r_cy[i];
                r_cz[i+1] <= r_cz[i];
            end
            r_cf[i+1] <= r_cf[i];
            r_cc[i+1] <= r_cc[i];
        end
    end

    // Stage E1: round the angle to Q3.12, add a quarter turn and subtract the facing.
    logic                 r_e1_v, r_e2_v, r_e3_v, r_e4_v, r_e5_v;
    logic signed [EW-1:0] r_e1_err, r_e2_err, r_e3_err;
    t_carry               r_e1_c, r_e2_c, r_e3_c;
    logic signed [ZW-1:0] w_zr;
    logic signed [EW-1:0] w_abs;

    always_comb begin
        w_zr  = (r_cz[N] + 20'sd8) >>> 4;
        w_abs = (r_e3_err < 0) ? -r_e3_err : r_e3_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_e3_v <= 1'b0;
        end else begin
            r_e1_v <= r_cv[N];
            r_e2_v <= r_e1_v;
            r_e3_v <= r_e2_v;
        end
        r_e1_err <= EW'(w_zr) + HALF_PI_E - EW'(r_cf[N]);
        r_e1_c   <= r_cc[N];
        // Remainder by a full turn, truncated toward zero.
        if (r_e1_err >= TWO_PI_E) begin
            r_e2_err <= r_e1_err - TWO_PI_E;
        end else if (r_e1_err <= -TWO_PI_E) begin
            r_e2_err <= r_e1_err + TWO_PI_E;
        end else begin
            r_e2_err <= r_e1_err;
        end
        r_e2_c <= r_e1_c;
        // Wrap into the closed turn about zero; both ends, minus pi and pi, are kept.
        if (r_e2_err > PI_E) begin
            r_e3_err <= r_e2_err - TWO_PI_E;
        end else if (r_e2_err < -PI_E) begin
            r_e3_err <= r_e2_err + TWO_PI_E;
        end else begin
            r_e3_err <= r_e2_err;
        end
        r_e3_c <= r_e2_c;
    end

    // Stage E4: magnitude of the error and the radius decisions; E5: scaling product.
    logic [SIZE_W-1:0] r_e4_size;
    t_side1            r_e4_s, r_e5_s;
    logic [PROD_W-1:0] r_e5_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_v <= 1'b0;
            r_e5_v <= 1'b0;
        end else begin
            r_e4_v <= r_e3_v;
            r_e5_v <= r_e4_v;
        end
        r_e4_size      <= w_abs[SIZE_W-1:0];
        r_e4_s.c       <= r_e3_c;
        r_e4_s.neg     <= r_e3_err < 0;
        r_e4_s.arrived <= w_abs[SIZE_W-1:0] < r_target_radius;
        r_e4_s.full    <= (r_slow_radius == '0) || (w_abs[SIZE_W-1:0] > r_slow_radius);
        r_e4_s.zero    <= w_abs == '0;
        r_e5_prod      <= PROD_W'(r_e4_s.c.maxa) * PROD_W'(r_e4_size);
        r_e5_s         <= r_e4_s;
    end

    // Desired rate scaling: product divided by the slow radius.
    logic                      w_d1_v;
    logic [MAX_W-1:0]          w_q1;
    t_side1                    w_s1;
    logic [$bits(t_side1)-1:0] w_s1_in;
    assign w_s1_in = r_e5_s;

    ftrc_div #(
        .DW (SIZE_W),
        .QW (MAX_W),
        .SW ($bits(t_side1))
    ) u_div_slow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e5_v),
        .i_rem   (r_e5_prod[PROD_W-1:MAX_W]),
        .i_low   (r_e5_prod[MAX_W-1:0]),
        .i_div   (r_slow_radius),
        .i_side  (w_s1_in),
        .o_valid (w_d1_v),
        .o_quo   (w_q1),
        .o_side  (w_s1)
    );

    // D1: signed desired rate; D2: rate error; D3: its magnitude; D4: saturation test.
    logic                     r_d1_v, r_d2_v, r_d3_v, r_d4_v;
    logic signed [DES_W-1:0]  r_d1_des, r_d2_diff;
    t_side2                   r_d1_s, r_d2_s, r_d3_s, r_d4_s;
    logic [DMAG_W-1:0]        r_d3_dmag, r_d4_dmag;
    logic [MAX_W-1:0]         w_mag;
    logic signed [DES_W-1:0]  w_mag_s, w_rate_s, w_dabs;

    always_comb begin
        if (w_s1.zero) begin
            w_mag = '0;
        end else if (w_s1.full) begin
            w_mag = w_s1.c.maxa;
        end else begin
            w_mag = w_q1;
        end
        w_mag_s  = {3'b000, w_mag};
        w_rate_s = {{2{r_d1_s.c.rate[RATE_W-1]}}, r_d1_s.c.rate};
        w_dabs   = (r_d2_diff < 0) ? -r_d2_diff : r_d2_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_d3_v <= 1'b0;
            r_d4_v <= 1'b0;
        end else begin
            r_d1_v <= w_d1_v;
            r_d2_v <= r_d1_v;
            r_d3_v <= r_d2_v;
            r_d4_v <= r_d3_v;
        end
        r_d1_des       <= w_s1.neg ? -w_mag_s : w_mag_s;
        r_d1_s.c       <= w_s1.c;
        r_d1_s.arrived <= w_s1.arrived;
        r_d1_s.dneg    <= 1'b0;
        r_d1_s.dzero   <= 1'b0;
        r_d1_s.sat     <= 1'b0;
        r_d2_diff      <= r_d1_des - w_rate_s;
        r_d2_s         <= r_d1_s;
        r_d3_dmag      <= w_dabs[DMAG_W-1:0];
        r_d3_s.c       <= r_d2_s.c;
        r_d3_s.arrived <= r_d2_s.arrived;
        r_d3_s.dneg    <= r_d2_diff < 0;
        r_d3_s.dzero   <= r_d2_diff == '0;
        r_d3_s.sat     <= r_d2_s.sat;
        r_d4_dmag      <= r_d3_dmag;
        r_d4_s.c       <= r_d3_s.c;
        r_d4_s.arrived <= r_d3_s.arrived;
        r_d4_s.dneg    <= r_d3_s.dneg;
        r_d4_s.dzero   <= r_d3_s.dzero;
        // A quotient of 2^19 or more is above any limit, and so is division by zero.
        r_d4_s.sat     <= {2'b00, r_d3_dmag[DMAG_W-1:7]} >= r_ttt;
    end

    // Acceleration magnitude: rate error times 4096 divided by the time to target.
    logic                      w_d2_v;
    logic [MAX_W-1:0]          w_q2;
    t_side2                    w_s2;
    logic [$bits(t_side2)-1:0] w_s2_in;
    assign w_s2_in = r_d4_s;

    ftrc_div #(
        .DW (TTT_W),
        .QW (MAX_W),
        .SW ($bits(t_side2))
    ) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d4_v),
        .i_rem   ({2'b00, r_d4_dmag[DMAG_W-1:7]}),
        .i_low   ({r_d4_dmag[6:0], 12'd0}),
        .i_div   (r_ttt),
        .i_side  (w_s2_in),
        .o_valid (w_d2_v),
        .o_quo   (w_q2),
        .o_side  (w_s2)
    );

    // F1: clamp to the limit; F2: apply the sign and the arrival override.
    logic                     r_f1_v;
    logic [MAX_W-1:0]         r_f1_amag;
    t_side2                   r_f1_s;
    logic signed [RATE_W-1:0] w_amag_s;

    always_comb begin
        w_amag_s = {1'b0, r_f1_amag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_f1_v <= w_d2_v;
            o_done <= r_f1_v;
        end
        if (w_s2.dzero) begin
            r_f1_amag <= '0;
        end else if (w_s2.sat || (w_q2 > w_s2.c.maxa)) begin
            r_f1_amag <= w_s2.c.maxa;
        end else begin
            r_f1_amag <= w_q2;
        end
        r_f1_s <= w_s2;
        if (r_f1_s.arrived) begin
            o_angular_accel     <= '0;
            o_rotation_rate_out <= '0;
        end else begin
            o_angular_accel     <= r_f1_s.dneg ? -w_amag_s : w_amag_s;
            o_rotation_rate_out <= r_f1_s.c.rate;
        end
        o_arrived <= r_f1_s.arrived;
    end

endmodule
